FILE: design/cbl_pkg.sv
// Shared widths and constants for the look-at camera basis pipeline.
`timescale 1ns / 1ps

package cbl_pkg;

  // Input coordinate and output axis component width.
  localparam int COORD_W    = 32;
  // Focal length and sensor size width.
  localparam int SIZE_W     = 31;
  // Normalized magnitude width, top bit in [2^30, 2^31).
  localparam int NORM_W     = 31;
  // Unit vector component width, signed Q2.30.
  localparam int UNIT_W     = 32;
  localparam int UNIT_SHIFT = 30;
  // Sum of squares, square root and divider numerator widths.
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int NUM_W      = 62;
  // Cross product width and width of the rounded down axis.
  localparam int CROSS_W    = 64;
  localparam int DOWN_W     = 34;
  // Difference of two coordinates.
  localparam int DIFF_W     = 33;

endpackage

FILE: design/cbl_isqrt.sv
// Fully pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module cbl_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [TAG_W-1:0]           tag_i,
  input  logic [cbl_pkg::SUM_W-1:0]  n_i,
  output logic                       valid_o,
  output logic [TAG_W-1:0]           tag_o,
  output logic [cbl_pkg::ROOT_W-1:0] root_o
);

  localparam int STAGES = cbl_pkg::SUM_W / 2;
  localparam int SW     = cbl_pkg::SUM_W;

  logic [SW-1:0]    n_q   [STAGES];
  logic [SW-1:0]    res_q [STAGES];
  logic [TAG_W-1:0] tag_q [STAGES];
  logic [STAGES-1:0] vld_q;

  // Valid bits shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * i);
    logic [SW-1:0]    n_in, res_in, trial, n_d, res_d;
    logic [TAG_W-1:0] tag_in;

    if (i == 0) begin : g_first
      assign n_in   = n_i;
      assign res_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign n_in   = n_q[i-1];
      assign res_in = res_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    // One restoring step of the digit-by-digit root.
    always_comb begin
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_d   = n_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i]   <= n_d;
        res_q[i] <= res_d;
        tag_q[i] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];
  assign root_o  = res_q[STAGES-1][cbl_pkg::ROOT_W-1:0];

endmodule

FILE: design/cbl_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
`timescale 1ns / 1ps

module cbl_div #(
  parameter int TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [TAG_W-1:0]           tag_i,
  input  logic [cbl_pkg::NUM_W-1:0]  num_i [3],
  input  logic [cbl_pkg::ROOT_W-1:0] den_i,
  output logic                       valid_o,
  output logic [TAG_W-1:0]           tag_o,
  output logic [cbl_pkg::NORM_W-1:0] quot_o [3]
);

  localparam int QW = cbl_pkg::NORM_W;
  localparam int DW = cbl_pkg::ROOT_W;
  localparam int STAGES = QW;

  logic [DW-1:0]     rem_q [STAGES][3];
  logic [QW-1:0]     lo_q  [STAGES][3];
  logic [QW-1:0]     q_q   [STAGES][3];
  logic [DW-1:0]     den_q [STAGES];
  logic [TAG_W-1:0]  tag_q [STAGES];
  logic [STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_st
    logic [DW-1:0]    rem_in [3];
    logic [QW-1:0]    lo_in  [3];
    logic [QW-1:0]    q_in   [3];
    logic [DW-1:0]    den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DW-1:0]    rem_d  [3];
    logic [QW-1:0]    lo_d   [3];
    logic [QW-1:0]    q_d    [3];

    for (genvar k = 0; k < 3; k++) begin : g_in
      if (j == 0) begin : g_first
        assign rem_in[k] = DW'(num_i[k][cbl_pkg::NUM_W-1:QW]);
        assign lo_in[k]  = num_i[k][QW-1:0];
        assign q_in[k]   = '0;
      end else begin : g_next
        assign rem_in[k] = rem_q[j-1][k];
        assign lo_in[k]  = lo_q[j-1][k];
        assign q_in[k]   = q_q[j-1][k];
      end
    end

    if (j == 0) begin : g_first
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    // Bring down one numerator bit and try the subtraction.
    always_comb begin
      logic [DW:0] part;
      logic        ge;
      for (int k = 0; k < 3; k++) begin
        part     = {rem_in[k], lo_in[k][QW-1]};
        ge       = (part >= {1'b0, den_in});
        rem_d[k] = ge ? DW'(part - {1'b0, den_in}) : part[DW-1:0];
        lo_d[k]  = lo_in[k] << 1;
        q_d[k]   = {q_in[k][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        lo_q[j]  <= lo_d;
        q_q[j]   <= q_d;
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];
  assign quot_o  = q_q[STAGES-1];

endmodule

FILE: design/cbl_unit.sv
// Pipelined vector normalizer producing a signed Q2.30 unit vector.
`timescale 1ns / 1ps

module cbl_unit #(
  parameter int VW    = 33,
  parameter int TAG_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [TAG_W-1:0]                  tag_i,
  input  logic signed [VW-1:0]              vec_i  [3],
  output logic                              valid_o,
  output logic [TAG_W-1:0]                  tag_o,
  output logic signed [cbl_pkg::UNIT_W-1:0] unit_o [3],
  output logic                              zero_o
);

  localparam int PW   = $clog2(VW);
  localparam int NW   = cbl_pkg::NORM_W;
  localparam int SQW  = 2 * NW;
  localparam int SW   = cbl_pkg::SUM_W;
  localparam int RW   = cbl_pkg::ROOT_W;
  localparam int UW   = cbl_pkg::UNIT_W;
  localparam int ST_W = TAG_W + 4 + 3 * NW;
  localparam int DT_W = TAG_W + 4;
  localparam logic [PW-1:0] TOP = PW'(NW - 1);

  logic [5:0] vld_q;

  // Stage 0: sign and magnitude.
  logic [VW-1:0]    mag0_d [3], mag0_q [3];
  logic [2:0]       neg0_q;
  logic [TAG_W-1:0] tag0_q;
  // Stage 1: leading one of all three magnitudes.
  logic [VW-1:0]    mag1_q [3];
  logic [2:0]       neg1_q;
  logic [TAG_W-1:0] tag1_q;
  logic [PW-1:0]    msb1_d, msb1_q;
  logic             zero1_d, zero1_q;
  // Stage 2: common shift into [2^30, 2^31).
  logic [NW-1:0]    norm2_d [3], norm2_q [3];
  logic [2:0]       neg2_q;
  logic [TAG_W-1:0] tag2_q;
  logic             zero2_q;
  // Stage 3: squares.
  logic [SQW-1:0]   sq3_q [3];
  logic [NW-1:0]    norm3_q [3];
  logic [2:0]       neg3_q;
  logic [TAG_W-1:0] tag3_q;
  logic             zero3_q;
  // Stage 4: sum of squares.
  logic [SW-1:0]    sum4_q;
  logic [NW-1:0]    norm4_q [3];
  logic [2:0]       neg4_q;
  logic [TAG_W-1:0] tag4_q;
  logic             zero4_q;
  // Root pipeline.
  logic             vld_s;
  logic [ST_W-1:0]  tag_s;
  logic [RW-1:0]    root_s;
  logic [NW-1:0]    norm_s [3];
  // Stage 5: rounded numerators.
  logic [cbl_pkg::NUM_W-1:0] num5_d [3], num5_q [3];
  logic [RW-1:0]    den5_q;
  logic [DT_W-1:0]  tag5_q;
  // Divider.
  logic             vld_v;
  logic [DT_W-1:0]  tag_v;
  logic [NW-1:0]    quot_v [3];
  // Stage 6: signed result.
  logic signed [UW-1:0] unit6_d [3], unit6_q [3];
  logic             zero6_q;
  logic [TAG_W-1:0] tag6_q;
  logic             vld6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_s, vld_q[3:0], valid_i};
    end
  end

  // Magnitudes and the leading-one search over their OR.
  always_comb begin
    logic [VW-1:0] any;
    for (int k = 0; k < 3; k++) begin
      mag0_d[k] = vec_i[k][VW-1] ? VW'(-vec_i[k]) : VW'(vec_i[k]);
    end
    any    = mag0_q[0] | mag0_q[1] | mag0_q[2];
    msb1_d = '0;
    for (int i = 0; i < VW; i++) begin
      if (any[i]) begin
        msb1_d = PW'(i);
      end
    end
    zero1_d = (any == '0);
  end

  // Shift all three by the same amount; low bits drop on a right shift.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb1_q >= TOP) begin
        norm2_d[k] = NW'(mag1_q[k] >> (msb1_q - TOP));
      end else begin
        norm2_d[k] = NW'(mag1_q[k][NW-1:0] << (TOP - msb1_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q  <= mag0_d;
      neg0_q  <= {vec_i[2][VW-1], vec_i[1][VW-1], vec_i[0][VW-1]};
      tag0_q  <= tag_i;
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;
      tag1_q  <= tag0_q;
      msb1_q  <= msb1_d;
      zero1_q <= zero1_d;
      norm2_q <= norm2_d;
      neg2_q  <= neg1_q;
      tag2_q  <= tag1_q;
      zero2_q <= zero1_q;
      for (int k = 0; k < 3; k++) begin
        sq3_q[k] <= SQW'(norm2_q[k]) * SQW'(norm2_q[k]);
      end
      norm3_q <= norm2_q;
      neg3_q  <= neg2_q;
      tag3_q  <= tag2_q;
      zero3_q <= zero2_q;
      sum4_q  <= SW'(sq3_q[0]) + SW'(sq3_q[1]) + SW'(sq3_q[2]);
      norm4_q <= norm3_q;
      neg4_q  <= neg3_q;
      tag4_q  <= tag3_q;
      zero4_q <= zero3_q;
    end
  end

  cbl_isqrt #(
    .TAG_W (ST_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[4]),
    .tag_i   ({tag4_q, neg4_q, zero4_q, norm4_q[2], norm4_q[1], norm4_q[0]}),
    .n_i     (sum4_q),
    .valid_o (vld_s),
    .tag_o   (tag_s),
    .root_o  (root_s)
  );

  // Numerator m * 2^30 + floor(L / 2) for round-to-nearest division.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_s[k] = tag_s[k*NW +: NW];
      num5_d[k] = cbl_pkg::NUM_W'({norm_s[k], {cbl_pkg::UNIT_SHIFT{1'b0}}})
                + cbl_pkg::NUM_W'(root_s >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num5_q <= num5_d;
      den5_q <= root_s;
      tag5_q <= tag_s[ST_W-1:3*NW];
    end
  end

  cbl_div #(
    .TAG_W (DT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[5]),
    .tag_i   (tag5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .valid_o (vld_v),
    .tag_o   (tag_v),
    .quot_o  (quot_v)
  );

  // Restore the signs.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unit6_d[k] = tag_v[k+1] ? -UW'(quot_v[k]) : UW'(quot_v[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit6_q <= unit6_d;
      zero6_q <= tag_v[0];
      tag6_q  <= tag_v[DT_W-1:4];
    end
  end

  // Last valid stage register is separate from the shift vector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld6_q <= 1'b0;
    end else if (en_i) begin
      vld6_q <= vld_v;
    end
  end

  assign valid_o = vld6_q;
  assign tag_o   = tag6_q;
  assign unit_o  = unit6_q;
  assign zero_o  = zero6_q;

endmodule

FILE: design/cbl_cross.sv
// Two-stage pipelined cross product of two signed 3-vectors.
`timescale 1ns / 1ps

module cbl_cross #(
  parameter int TAG_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [TAG_W-1:0]                   tag_i,
  input  logic signed [cbl_pkg::UNIT_W-1:0]  a_i [3],
  input  logic signed [cbl_pkg::COORD_W-1:0] b_i [3],
  output logic                               valid_o,
  output logic [TAG_W-1:0]                   tag_o,
  output logic signed [cbl_pkg::CROSS_W-1:0] c_o [3]
);

  localparam int CW = cbl_pkg::CROSS_W;

  logic signed [CW-1:0] prod_q [6];
  logic signed [CW-1:0] c_q    [3];
  logic [TAG_W-1:0]     tag_q  [2];
  logic [1:0]           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // Six products, then the three differences.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= CW'(a_i[1]) * CW'(b_i[2]);
      prod_q[1] <= CW'(a_i[2]) * CW'(b_i[1]);
      prod_q[2] <= CW'(a_i[2]) * CW'(b_i[0]);
      prod_q[3] <= CW'(a_i[0]) * CW'(b_i[2]);
      prod_q[4] <= CW'(a_i[0]) * CW'(b_i[1]);
      prod_q[5] <= CW'(a_i[1]) * CW'(b_i[0]);
      c_q[0]    <= prod_q[0] - prod_q[1];
      c_q[1]    <= prod_q[2] - prod_q[3];
      c_q[2]    <= prod_q[4] - prod_q[5];
      tag_q[0]  <= tag_i;
      tag_q[1]  <= tag_q[0];
    end
  end

  assign valid_o = vld_q[1];
  assign tag_o   = tag_q[1];
  assign c_o     = c_q;

endmodule

FILE: design/cbl_scale.sv
// Three-stage scaler: sign * round(|u| * s / 2^K), saturated to 32 bits.
`timescale 1ns / 1ps

module cbl_scale #(
  parameter int UW = 32,
  parameter int K  = 30
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [UW-1:0]               u_i,
  input  logic [cbl_pkg::SIZE_W-1:0]         s_i,
  output logic signed [cbl_pkg::COORD_W-1:0] y_o
);

  localparam int SZ = cbl_pkg::SIZE_W;
  localparam int PW = UW + SZ;
  localparam int RW = PW + 1 - K;
  localparam int OW = cbl_pkg::COORD_W;
  localparam logic [RW-1:0] NEG_LIM = RW'(64'h8000_0000);
  localparam logic [RW-1:0] POS_LIM = RW'(64'h7FFF_FFFF);

  logic [UW-1:0]  mag_q;
  logic [SZ-1:0]  s_q;
  logic           neg1_q, neg2_q;
  logic [PW-1:0]  prod_q;
  logic [PW:0]    rnd;
  logic [RW-1:0]  r;
  logic [OW-1:0]  y_d, y_q;

  // Round half up on the magnitude, then saturate per sign.
  always_comb begin
    rnd = (PW+1)'(prod_q) + ((PW+1)'(1) << (K - 1));
    r   = rnd[PW:K];
    if (neg2_q) begin
      y_d = (r > NEG_LIM) ? OW'(32'h8000_0000) : -r[OW-1:0];
    end else begin
      y_d = (r > POS_LIM) ? OW'(32'h7FFF_FFFF) : r[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= u_i[UW-1];
      mag_q  <= u_i[UW-1] ? UW'(-u_i) : UW'(u_i);
      s_q    <= s_i;
      neg2_q <= neg1_q;
      prod_q <= PW'(mag_q) * PW'(s_q);
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: design/camera_basis_from_look_at_top.sv
// Top level of the look-at camera basis pipeline with stream ports.
`timescale 1ns / 1ps

// Look-at camera basis. Each input beat carries a camera position, a look-at
// point, a world-up vector, a focal length and the sensor size, all in
// Q16.16; each output beat carries forward * focal, right * width / 2 and
// down * height / 2, saturated to 32 bits, plus a degenerate flag that is
// set, with all axes zero, when the view direction or the right axis has no
// length. The pipeline takes one beat per cycle while the output is not stalled
// and returns results in order; its depth comes mainly from the two normalizers,
// each a 32-stage square root followed by a 31-stage divider. A stalled output
// holds the whole pipeline, and the input is ready whenever the output
// register is empty or being taken.
module camera_basis_from_look_at_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pos_x, pos_y, pos_z, target_x, target_y, target_z, up_x, up_y, up_z
  // (32 bits each), focal, sensor_w, sensor_h (31 bits each), 3 zero bits
  input  logic [383:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, down_x, down_y, down_z
  output logic [287:0] m_axis_tdata,
  // degenerate
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);

  localparam int CW  = cbl_pkg::COORD_W;
  localparam int SZ  = cbl_pkg::SIZE_W;
  localparam int UW  = cbl_pkg::UNIT_W;
  localparam int XW  = cbl_pkg::CROSS_W;
  localparam int DNW = cbl_pkg::DOWN_W;
  localparam int US  = cbl_pkg::UNIT_SHIFT;
  localparam int SIZES_W = 3 * SZ;
  localparam int T1_W = SIZES_W + 3 * CW;
  localparam int T2_W = SIZES_W + 1 + 3 * UW;
  localparam int T3_W = T2_W + 1 + 3 * UW;

  logic en;
  logic [2:0] vs_q;
  logic [2:0] deg_q;

  // The whole pipeline advances unless the output beat is stuck.
  assign en            = !vs_q[2] || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage: exact differences and side data.
  logic signed [cbl_pkg::DIFF_W-1:0] diff_q [3];
  logic [T1_W-1:0] tag_a_q;
  logic            va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= $signed({s_axis_tdata[(k+3)*CW+CW-1], s_axis_tdata[(k+3)*CW +: CW]})
                   - $signed({s_axis_tdata[k*CW+CW-1], s_axis_tdata[k*CW +: CW]});
      end
      tag_a_q <= {s_axis_tdata[9*CW +: SIZES_W], s_axis_tdata[6*CW +: 3*CW]};
    end
  end

  // Forward axis.
  logic                 v1;
  logic [T1_W-1:0]      tag1;
  logic signed [UW-1:0] fwd1 [3];
  logic                 zero1;

  cbl_unit #(
    .VW    (cbl_pkg::DIFF_W),
    .TAG_W (T1_W)
  ) u_unit_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .tag_i   (tag_a_q),
    .vec_i   (diff_q),
    .valid_o (v1),
    .tag_o   (tag1),
    .unit_o  (fwd1),
    .zero_o  (zero1)
  );

  // forward x up
  logic signed [CW-1:0] up1 [3];
  logic                 vc1;
  logic [T2_W-1:0]      tagc1;
  logic signed [XW-1:0] rc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      up1[k] = $signed(tag1[k*CW +: CW]);
    end
  end

  cbl_cross #(
    .TAG_W (T2_W)
  ) u_cross_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .tag_i   ({tag1[T1_W-1:3*CW], zero1, fwd1[2], fwd1[1], fwd1[0]}),
    .a_i     (fwd1),
    .b_i     (up1),
    .valid_o (vc1),
    .tag_o   (tagc1),
    .c_o     (rc)
  );

  // Right axis.
  logic                 v2;
  logic [T2_W-1:0]      tag2;
  logic signed [UW-1:0] rgt2 [3];
  logic                 zero2;
  logic signed [UW-1:0] fwd2 [3];

  cbl_unit #(
    .VW    (XW),
    .TAG_W (T2_W)
  ) u_unit_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc1),
    .tag_i   (tagc1),
    .vec_i   (rc),
    .valid_o (v2),
    .tag_o   (tag2),
    .unit_o  (rgt2),
    .zero_o  (zero2)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fwd2[k] = $signed(tag2[k*UW +: UW]);
    end
  end

  // forward x right gives the down axis in Q.60.
  logic                 vc2;
  logic [T3_W-1:0]      tagc2;
  logic signed [XW-1:0] dc [3];

  cbl_cross #(
    .TAG_W (T3_W)
  ) u_cross_down (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .tag_i   ({tag2, zero2, rgt2[2], rgt2[1], rgt2[0]}),
    .a_i     (fwd2),
    .b_i     (rgt2),
    .valid_o (vc2),
    .tag_o   (tagc2),
    .c_o     (dc)
  );

  // Round the down axis back to Q4.30, ties away from zero.
  logic [XW-1:0]         dmag_q [3];
  logic [2:0]            dneg_q;
  logic [6*UW-1:0]       fr_r1_q, fr_r2_q;
  logic [SIZES_W-1:0]    sz_r1_q, sz_r2_q;
  logic                  deg_r1_q, deg_r2_q;
  logic signed [DNW-1:0] dn_d [3], dn_q [3];
  logic [1:0]            vr_q;

  always_comb begin
    logic [XW:0]    rnd;
    logic [DNW-1:0] rm;
    for (int k = 0; k < 3; k++) begin
      rnd     = (XW+1)'(dmag_q[k]) + ((XW+1)'(1) << (US - 1));
      rm      = rnd[US+DNW-1:US];
      dn_d[k] = dneg_q[k] ? (~rm + DNW'(1)) : rm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dneg_q[k] <= dc[k][XW-1];
        dmag_q[k] <= dc[k][XW-1] ? XW'(-dc[k]) : XW'(dc[k]);
      end
      fr_r1_q  <= {tagc2[3*UW+1 +: 3*UW], tagc2[3*UW-1:0]};
      sz_r1_q  <= tagc2[T3_W-1 -: SIZES_W];
      deg_r1_q <= tagc2[3*UW] | tagc2[6*UW+1];
      dn_q     <= dn_d;
      fr_r2_q  <= fr_r1_q;
      sz_r2_q  <= sz_r1_q;
      deg_r2_q <= deg_r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q  <= '0;
      vs_q  <= '0;
    end else if (en) begin
      vr_q  <= {vr_q[0], vc2};
      vs_q  <= {vs_q[1:0], vr_q[1]};
    end
  end

  // Scale by the focal length and half the sensor sizes; a zero scale
  // forces every axis to zero for a degenerate frame.
  logic [SZ-1:0]        focal_s, width_s, height_s;
  logic signed [CW-1:0] y [9];

  assign focal_s  = deg_r2_q ? '0 : sz_r2_q[0 +: SZ];
  assign width_s  = deg_r2_q ? '0 : sz_r2_q[SZ +: SZ];
  assign height_s = deg_r2_q ? '0 : sz_r2_q[2*SZ +: SZ];

  for (genvar k = 0; k < 3; k++) begin : g_scale
    cbl_scale #(
      .UW (UW),
      .K  (US)
    ) u_fwd (
      .clk_i (clk_i),
      .en_i  (en),
      .u_i   ($signed(fr_r2_q[3*UW + k*UW +: UW])),
      .s_i   (focal_s),
      .y_o   (y[k])
    );
    cbl_scale #(
      .UW (UW),
      .K  (US + 1)
    ) u_right (
      .clk_i (clk_i),
      .en_i  (en),
      .u_i   ($signed(fr_r2_q[k*UW +: UW])),
      .s_i   (width_s),
      .y_o   (y[3+k])
    );
    cbl_scale #(
      .UW (DNW),
      .K  (US + 1)
    ) u_down (
      .clk_i (clk_i),
      .en_i  (en),
      .u_i   (dn_q[k]),
      .s_i   (height_s),
      .y_o   (y[6+k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= {deg_q[1:0], deg_r2_q};
    end
  end

  // Output beat.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_axis_tdata[k*CW +: CW] = y[k];
    end
  end

  assign m_axis_tuser  = deg_q[2];
  assign m_axis_tvalid = vs_q[2];

endmodule

FILE: design/cbl_checker.sv
// Port-level checks for the camera basis top level, bound to it.
`timescale 1ns / 1ps

module cbl_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [383:0] s_axis_tdata,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // A degenerate frame carries all-zero axes.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("degenerate beat with nonzero axes");

  // The input is ready exactly when the output register can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // A stalled output beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind camera_basis_from_look_at_top cbl_checker u_cbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
